// ----- src/ctt_pkg.sv -----
// Package for the countdown timer table: result kinds, sequencer states,
// table entry layout and the word handed from sequencer to output stage.
// No dependencies.
package ctt_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int DELAY_W     = 16;
    localparam int TAG_W       = 16;
    localparam int SLOT_W      = 6;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_NONE     = 2'd3
    } ctt_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } ctt_state_t;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic               alive;
        logic [DELAY_W-1:0] remaining;
        logic [TAG_W-1:0]   tag;
        logic               cb_arg;
    } ctt_entry_t;

    typedef struct packed {
        ctt_kind_t          kind;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic               cb_arg;
    } ctt_result_t;

    typedef struct packed {
        logic        push;
        logic        last;
        ctt_result_t res;
    } ctt_push_t;

endpackage

// ----- src/ctt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ctt_ctrl.sv -----
// Sequencer: takes add and tick words, walks the table one slot a cycle while no
// fired result waits on the output, via the shared decrement/compare unit. Uses ctt_pkg; drives ctt_ram.
module ctt_ctrl #(
    parameter int SLOTS = ctt_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(SLOTS),
    parameter int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_cmd,
    input  logic [ctt_pkg::DELAY_W-1:0]       in_delay,
    input  logic [ctt_pkg::TAG_W-1:0]         in_tag,
    input  logic                              in_cb_arg,
    output logic                              ram_we,
    output logic [IDX_W-1:0]                  ram_waddr,
    output ctt_pkg::ctt_entry_t               ram_wdata,
    output logic                              ram_re,
    output logic [IDX_W-1:0]                  ram_raddr,
    input  ctt_pkg::ctt_entry_t               ram_rdata,
    input  logic                              out_free,
    output ctt_pkg::ctt_push_t                out_push
);
    import ctt_pkg::*;

    ctt_state_t  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic        hold_valid_reg, hold_valid_next;
    ctt_result_t hold_reg, hold_next;

    logic        accept;
    logic        fire_now;
    logic        stall;
    logic        walk_done;
    logic [31:0] count32;
    logic [31:0] idx32;

    assign accept    = in_valid && in_ready;
    assign count32   = 32'(count_reg);
    assign idx32     = 32'(idx_reg);
    assign fire_now  = ram_rdata.alive && (ram_rdata.remaining[DELAY_W-1:1] == '0);
    assign stall     = fire_now && hold_valid_reg && !out_free;
    assign walk_done = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
        end
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        out_push        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    if (in_cmd == CMD_ADD) begin
                        hold_valid_next = 1'b1;
                        hold_next       = '0;
                        state_next      = ST_FINISH;
                        if (count32 == SLOTS) begin
                            hold_next.kind = KIND_ADD_FULL;
                        end else begin
                            hold_next.kind          = KIND_ADD_OK;
                            hold_next.slot          = count32[SLOT_W-1:0];
                            ram_we                  = 1'b1;
                            ram_waddr               = count_reg[IDX_W-1:0];
                            ram_wdata.alive         = 1'b1;
                            ram_wdata.remaining     = in_delay;
                            ram_wdata.tag           = in_tag;
                            ram_wdata.cb_arg        = in_cb_arg;
                            count_next              = count_reg + CNT_W'(1);
                        end
                    end else if (count_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    if (ram_rdata.alive) begin
                        ram_we = 1'b1;
                        if (fire_now) begin
                            ram_wdata.alive     = 1'b0;
                            ram_wdata.remaining = '0;
                        end else begin
                            ram_wdata.remaining = ram_rdata.remaining - DELAY_W'(1);
                        end
                    end
                    if (fire_now) begin
                        if (hold_valid_reg) begin
                            out_push.push = 1'b1;
                            out_push.last = 1'b0;
                            out_push.res  = hold_reg;
                        end
                        hold_valid_next    = 1'b1;
                        hold_next.kind     = KIND_FIRED;
                        hold_next.slot     = idx32[SLOT_W-1:0];
                        hold_next.tag      = ram_rdata.tag;
                        hold_next.cb_arg   = ram_rdata.cb_arg;
                    end
                    if (walk_done) begin
                        state_next = ST_FINISH;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + IDX_W'(1);
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_push.push = 1'b1;
                    out_push.last = 1'b1;
                    if (hold_valid_reg) begin
                        out_push.res = hold_reg;
                    end else begin
                        out_push.res      = '0;
                        out_push.res.kind = KIND_NONE;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/countdown_timer_table.sv -----
// Countdown timer table, top level: stream ports, table RAM, sequencer, output register.
// Add: the result goes to the sequencer's hold register, then to the output register once
// it is free; the next word is taken after that. Tick: each slot handed out so far is
// walked, then the last result is pushed and the next word taken; the walk pauses while
// a fired result waits on the output. One word in flight at a time.
// Reset (aresetn, synchronous) clears the sequencer, slot count and output valid;
// the table RAM is not cleared, slots past the count are never read.
module countdown_timer_table #(
    parameter int SLOTS = ctt_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] delay_seconds, [31:16] callback_tag, [32] with_argument, [39:33] zero
    input  logic [ctt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] cmd
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] slot, [21:6] fired_tag, [22] fired_with_argument, [23] zero
    output logic [ctt_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] kind
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import ctt_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    ctt_entry_t       ram_wdata;
    ctt_entry_t       ram_rdata;
    logic             out_free;
    ctt_push_t        out_push;

    logic             m_tvalid_reg;
    logic             m_tlast_reg;
    ctt_result_t      m_res_reg;

    ctt_ram #(
        .WIDTH ($bits(ctt_entry_t)),
        .DEPTH (SLOTS),
        .ADDR_W(IDX_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ctt_ctrl #(
        .SLOTS(SLOTS),
        .IDX_W(IDX_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_delay   (s_tdata[DELAY_W-1:0]),
        .in_tag     (s_tdata[DELAY_W+TAG_W-1:DELAY_W]),
        .in_cb_arg  (s_tdata[DELAY_W+TAG_W]),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_free   (out_free),
        .out_push   (out_push)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_push.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_push.push) begin
            m_res_reg   <= out_push.res;
            m_tlast_reg <= out_push.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {1'b0, m_res_reg.cb_arg, m_res_reg.tag, m_res_reg.slot};

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for countdown_timer_table: queued add and tick words,
// a bit-exact model of the timer slots, and checks of every result word.
// Depends on ctt_pkg and countdown_timer_table.
`timescale 1ns / 100ps

module tb_top;
    import ctt_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 440;

    typedef struct packed {
        logic        cmd;
        logic [15:0] delay;
        logic [15:0] tag;
        logic        warg;
        logic        hold;
    } timer_cmd_t;

    typedef struct packed {
        ctt_kind_t   kind;
        logic [5:0]  slot;
        logic [15:0] tag;
        logic        warg;
        logic        last;
    } timer_event_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    timer_cmd_t   pending_words[$];
    timer_event_t timer_events[$];

    // timer table as the bench sees it
    logic        slot_live[TABLE_SLOTS];
    logic [16:0] slot_count[TABLE_SLOTS];
    logic [15:0] slot_tag[TABLE_SLOTS];
    logic        slot_warg[TABLE_SLOTS];
    logic [6:0]  next_slot;

    int mismatches  = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int rx_stall    = 0;
    int cycle_count = 0;
    timer_cmd_t next_word;

    countdown_timer_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic timer_cmd_t make_word(logic cmd, logic [15:0] delay,
                                             logic [15:0] tag, logic warg, logic hold);
        timer_cmd_t w;
        w.cmd   = cmd;
        w.delay = delay;
        w.tag   = tag;
        w.warg  = warg;
        w.hold  = hold;
        return w;
    endfunction

    function automatic timer_event_t make_event(ctt_kind_t kind, logic [5:0] slot,
                                                logic [15:0] tag, logic warg, logic last);
        timer_event_t e;
        e.kind = kind;
        e.slot = slot;
        e.tag  = tag;
        e.warg = warg;
        e.last = last;
        return e;
    endfunction

    function automatic timer_cmd_t random_word(logic hold);
        logic [15:0] delay;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            delay = 16'($urandom_range(0, 15));
        end else if (pick < 9) begin
            delay = 16'($urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 3))
                0: delay = 16'd0;
                1: delay = 16'd1;
                2: delay = 16'd2;
                default: delay = 16'hFFFF;
            endcase
        end
        return make_word(($urandom_range(0, 99) < 35) ? CMD_ADD : CMD_TICK, delay,
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), hold);
    endfunction

    function automatic void predict_timer_events(logic cmd, logic [15:0] delay,
                                                 logic [15:0] tag, logic warg);
        int fired[$];
        if (cmd == CMD_ADD) begin
            if (next_slot >= 7'(TABLE_SLOTS)) begin
                timer_events.push_back(make_event(KIND_ADD_FULL, '0, '0, 1'b0, 1'b1));
            end else begin
                slot_live[next_slot]  = 1'b1;
                slot_count[next_slot] = {1'b0, delay};
                slot_tag[next_slot]   = tag;
                slot_warg[next_slot]  = warg;
                timer_events.push_back(make_event(KIND_ADD_OK, next_slot[5:0], '0, 1'b0,
                                                  1'b1));
                next_slot = next_slot + 7'd1;
            end
        end else begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_live[i]) begin
                    if (slot_count[i] <= 17'd1) begin
                        fired.push_back(i);
                        slot_live[i]  = 1'b0;
                        slot_count[i] = '0;
                    end else begin
                        slot_count[i] = slot_count[i] - 17'd1;
                    end
                end
            end
            if (fired.size() == 0) begin
                timer_events.push_back(make_event(KIND_NONE, '0, '0, 1'b0, 1'b1));
            end
            for (int k = 0; k < fired.size(); k++) begin
                timer_events.push_back(make_event(KIND_FIRED, 6'(fired[k]), slot_tag[fired[k]],
                                                  slot_warg[fired[k]],
                                                  k == fired.size() - 1));
            end
        end
    endfunction

    // sender: bursts with random gaps; a held word waits until all expected results have been received
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0 && (!pending_words[0].hold ||
                         (!s_tvalid && timer_events.size() == 0))) begin
                next_word = pending_words.pop_front();
                s_tdata   <= {7'b0, next_word.warg, next_word.tag, next_word.delay};
                s_tuser   <= next_word.cmd;
                s_tvalid  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: always ready, coin flips, or long stalls, switching between the three modes in turn
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            case ((cycle_count / 300) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (rx_stall > 0) begin
                        m_tready <= 1'b0;
                        rx_stall <= rx_stall - 1;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            rx_stall <= $urandom_range(1, 20);
                    end
                end
            endcase
        end
    end

    // monitor: check result words, then predict for the accepted input word
    always @(posedge aclk) begin
        timer_event_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (timer_events.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: kind=%0d slot=%0d tag=%h warg=%b last=%b",
                                 m_tuser, m_tdata[5:0], m_tdata[21:6], m_tdata[22], m_tlast);
                end else begin
                    want = timer_events.pop_front();
                    if (m_tuser !== want.kind || m_tdata[5:0] !== want.slot ||
                        m_tdata[21:6] !== want.tag || m_tdata[22] !== want.warg ||
                        m_tlast !== want.last) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected kind=%0d slot=%0d tag=%h warg=%b last=%b, got kind=%0d slot=%0d tag=%h warg=%b last=%b",
                                     want.kind, want.slot, want.tag, want.warg, want.last,
                                     m_tuser, m_tdata[5:0], m_tdata[21:6], m_tdata[22], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_timer_events(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[32]);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_count[i] = '0;
            slot_tag[i]   = '0;
            slot_warg[i]  = 1'b0;
        end
        next_slot = '0;

        pending_words.push_back(make_word(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'd0, 16'h0000, 1'b0, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'd1, 16'hFFFF, 1'b1, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'hFFFF, 16'hA5A5, 1'b1, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'd2, 16'h1234, 1'b0, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'd3, 16'h5A5A, 1'b1, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'd2, 16'hC3C3, 1'b1, 1'b0));
        // tick with all add fields set: they must be ignored
        pending_words.push_back(make_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        pending_words.push_back(make_word(CMD_TICK, 16'h8000, 16'h0001, 1'b0, 1'b0));
        pending_words.push_back(make_word(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0));
        pending_words.push_back(make_word(CMD_TICK, 16'h5555, 16'hAAAA, 1'b1, 1'b0));
        pending_words.push_back(make_word(CMD_ADD, 16'h8000, 16'h7FFF, 1'b0, 1'b1));
        pending_words.push_back(make_word(CMD_ADD, 16'd1, 16'h8001, 1'b1, 1'b0));
        pending_words.push_back(make_word(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0));
        for (int i = 0; i < RANDOM_WORDS; i++)
            pending_words.push_back(random_word(i % 150 == 149));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (timer_events.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (mismatches == 0 && timer_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
